@@ rtl/core/rbs_pkg.sv @@
package rbs_pkg;

  localparam int SQRT_STEPS = 16;
  localparam int DIV_STEPS  = 34;
  localparam int SQUARINGS  = 12;

  localparam logic [16:0] COS_ONE   = 17'd65536;
  localparam logic [33:0] K_CLAMP   = 34'h2_0000_0000;
  localparam logic [31:0] E_ONE     = 32'h8000_0000;
  localparam logic [16:0] RECIP_SIX = 17'd43691;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] root;
    logic [31:0] adot;
    logic [15:0] eta;
    logic [15:0] omega;
  } rbs_sqrt_t;

  typedef struct packed {
    logic [15:0] rem_c;
    logic [15:0] rem_k;
    logic [33:0] num_c;
    logic [33:0] num_k;
    logic [33:0] quo_c;
    logic [33:0] quo_k;
    logic [15:0] div;
    logic [15:0] eta;
  } rbs_div_t;

  typedef struct packed {
    logic [31:0] e;
    logic        zero;
  } rbs_sqr_t;

endpackage

@@ rtl/core/rbs_sqrt_cell.sv @@
module rbs_sqrt_cell #(
  parameter int BIT_POS = 30
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              vin,
  input  rbs_pkg::rbs_sqrt_t din,
  output logic              vout,
  output rbs_pkg::rbs_sqrt_t dout
);

  localparam logic [32:0] BIT = 33'd1 << BIT_POS;

  logic [32:0]        trial;
  rbs_pkg::rbs_sqrt_t dout_next;

  always_comb begin
    trial = {1'b0, din.root} + BIT;
    dout_next = din;
    if ({1'b0, din.rem} >= trial) begin
      dout_next.rem  = 32'(({1'b0, din.rem} - trial));
      dout_next.root = 32'(({1'b0, din.root} >> 1) + BIT);
    end else begin
      dout_next.root = din.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
    if (en) begin
      dout <= dout_next;
    end
  end

endmodule

@@ rtl/core/rbs_div_cell.sv @@
module rbs_div_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             vin,
  input  rbs_pkg::rbs_div_t din,
  output logic             vout,
  output rbs_pkg::rbs_div_t dout
);

  logic [16:0]       sh_c;
  logic [16:0]       sh_k;
  logic              ge_c;
  logic              ge_k;
  rbs_pkg::rbs_div_t dout_next;

  // one restoring step for both quotients against the shared divisor
  always_comb begin
    sh_c = {din.rem_c, din.num_c[33]};
    sh_k = {din.rem_k, din.num_k[33]};
    ge_c = sh_c >= {1'b0, din.div};
    ge_k = sh_k >= {1'b0, din.div};
    dout_next       = din;
    dout_next.num_c = {din.num_c[32:0], 1'b0};
    dout_next.num_k = {din.num_k[32:0], 1'b0};
    dout_next.rem_c = ge_c ? 16'(sh_c - {1'b0, din.div}) : sh_c[15:0];
    dout_next.rem_k = ge_k ? 16'(sh_k - {1'b0, din.div}) : sh_k[15:0];
    dout_next.quo_c = {din.quo_c[32:0], ge_c};
    dout_next.quo_k = {din.quo_k[32:0], ge_k};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
    if (en) begin
      dout <= dout_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    vout && dout.div != 16'd0 |-> dout.rem_c < dout.div && dout.rem_k < dout.div)
    else $error("divider remainder not below divisor");
`endif

endmodule

@@ rtl/core/rbs_sqr_cell.sv @@
module rbs_sqr_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             vin,
  input  rbs_pkg::rbs_sqr_t din,
  output logic             vout,
  output rbs_pkg::rbs_sqr_t dout
);

  logic [63:0] prod;
  logic [63:0] rnd;

  always_comb begin
    prod = 64'(din.e) * 64'(din.e);
    rnd  = prod + 64'h4000_0000;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
    if (en) begin
      dout.e    <= rnd[62:31];
      dout.zero <= din.zero;
    end
  end

`ifndef NO_ASSERTIONS
  a_e_bounded: assert property (@(posedge clk) disable iff (rst)
    vin && din.e <= rbs_pkg::E_ONE && en |=> dout.e <= rbs_pkg::E_ONE)
    else $error("squaring result above one");
`endif

endmodule

@@ rtl/core/rough_boundary_specularity_core.sv @@
// rough boundary specularity, fully pipelined
// input channel: in_valid / in_stall with velocity, unit normal, roughness
// and angular frequency as separate ports; a beat moves when valid is high
// and stall is low
// output channel: out_valid / out_stall with specular_probability in Q0.16
// 72 register stages from the input beat to the output register: 1 front
// stage, 16 square-root cells, 34 divider cells, 8 exponent stages,
// 12 squaring cells, 1 output register
// throughput: one beat per cycle while not stalled; every stage is a register
// and the row of divider cells, one quotient bit per cell, sets the depth
// out_stall with out_valid high freezes the whole pipeline and raises in_stall
// in the same cycle; held results stay on the output ports unchanged
// reset clears all valid bits; no result is pending after reset
module rough_boundary_specularity_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] velocity_x,
  input  logic signed [15:0] velocity_y,
  input  logic signed [15:0] velocity_z,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic signed [15:0] normal_z,
  input  logic        [15:0] roughness_nm,
  input  logic        [15:0] angular_frequency,
  output logic               out_valid,
  input  logic               out_stall,
  output logic        [15:0] specular_probability
);

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage 1: squared speed and dot product
  logic               v1;
  logic        [31:0] s2;
  logic signed [33:0] dot;
  logic        [15:0] eta1;
  logic        [15:0] omega1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      s2 <= 32'(32'(velocity_x * velocity_x) + 32'(velocity_y * velocity_y)
              + 32'(velocity_z * velocity_z));
      dot <= 34'(velocity_x * normal_x) + 34'(velocity_y * normal_y)
             + 34'(velocity_z * normal_z);
      eta1   <= roughness_nm;
      omega1 <= angular_frequency;
    end
  end

  // square root row
  localparam int SQRT_STEPS_L = rbs_pkg::SQRT_STEPS;
  logic               sq_v [SQRT_STEPS_L+1];
  rbs_pkg::rbs_sqrt_t sq_d [SQRT_STEPS_L+1];

  logic [33:0] dot_abs;
  assign dot_abs = dot[33] ? 34'(-dot) : 34'(dot);

  always_comb begin
    sq_v[0]       = v1;
    sq_d[0].rem   = s2;
    sq_d[0].root  = 32'd0;
    sq_d[0].adot  = dot_abs[31:0];
    sq_d[0].eta   = eta1;
    sq_d[0].omega = omega1;
  end

  for (genvar i = 0; i < SQRT_STEPS_L; i++) begin : g_sqrt
    rbs_sqrt_cell #(.BIT_POS(30 - 2 * i)) u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .vin  (sq_v[i]),
      .din  (sq_d[i]),
      .vout (sq_v[i+1]),
      .dout (sq_d[i+1])
    );
  end

  // divider row: cos and k share the speed as divisor
  localparam int DIV_STEPS_L = rbs_pkg::DIV_STEPS;
  logic              dv_v [DIV_STEPS_L+1];
  rbs_pkg::rbs_div_t dv_d [DIV_STEPS_L+1];

  logic [15:0] speed;
  assign speed = (sq_d[SQRT_STEPS_L].root[15:0] == 16'd0) ? 16'd1
                 : sq_d[SQRT_STEPS_L].root[15:0];

  always_comb begin
    dv_v[0]       = sq_v[SQRT_STEPS_L];
    dv_d[0].rem_c = 16'd0;
    dv_d[0].rem_k = 16'd0;
    dv_d[0].num_c = {sq_d[SQRT_STEPS_L].adot, 2'b00};
    dv_d[0].num_k = {sq_d[SQRT_STEPS_L].omega, 18'd0};
    dv_d[0].quo_c = 34'd0;
    dv_d[0].quo_k = 34'd0;
    dv_d[0].div   = speed;
    dv_d[0].eta   = sq_d[SQRT_STEPS_L].eta;
  end

  for (genvar i = 0; i < DIV_STEPS_L; i++) begin : g_div
    rbs_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .vin  (dv_v[i]),
      .din  (dv_d[i]),
      .vout (dv_v[i+1]),
      .dout (dv_d[i+1])
    );
  end

  // clamps; k above 2^33 always drives x past the cutoff when a is nonzero
  logic [16:0] cosv;
  logic [33:0] kv;
  always_comb begin
    cosv = (dv_d[DIV_STEPS_L].quo_c > 34'(rbs_pkg::COS_ONE)) ? rbs_pkg::COS_ONE
           : dv_d[DIV_STEPS_L].quo_c[16:0];
    if (dv_d[DIV_STEPS_L].quo_k == 34'd0) begin
      kv = 34'd1;
    end else if (dv_d[DIV_STEPS_L].quo_k > rbs_pkg::K_CLAMP) begin
      kv = rbs_pkg::K_CLAMP;
    end else begin
      kv = dv_d[DIV_STEPS_L].quo_k;
    end
  end

  // stage c: a = eta*cos >> 8
  logic        vc;
  logic [24:0] a_c;
  logic [33:0] k_c;
  logic [32:0] eta_cos;
  assign eta_cos = 33'(dv_d[DIV_STEPS_L].eta) * 33'(cosv);

  // stage d: partial products of a*k
  logic        vd;
  logic [41:0] pl_d;
  logic [41:0] ph_d;

  // stage e: x and cutoff
  logic        ve;
  logic [17:0] x_e;
  logic        zero_e;
  logic [58:0] prod_ak;
  assign prod_ak = 59'(pl_d) + (59'(ph_d) << 17);

  // stage f: y
  logic        vf;
  logic [19:0] y_f;
  logic        zero_f;
  logic [35:0] xx;
  assign xx = 36'(x_e) * 36'(x_e);

  // stage g: t and t2
  logic        vg;
  logic [22:0] t_g;
  logic [14:0] t2_g;
  logic        zero_g;
  logic [45:0] tt;
  assign tt = 46'({y_f, 3'b000}) * 46'({y_f, 3'b000});

  // stage h: t3
  logic        vh;
  logic [22:0] t_h;
  logic [14:0] t2_h;
  logic [6:0]  t3_h;
  logic        zero_h;
  logic [37:0] t2t;
  assign t2t = 38'(t2_g) * 38'(t_g);

  // stage i: t3/6 by reciprocal
  logic        vi;
  logic [22:0] t_i;
  logic [14:0] t2_i;
  logic [4:0]  d6_i;
  logic        zero_i;
  logic [23:0] t3r;
  assign t3r = 24'(t3_h) * 24'(rbs_pkg::RECIP_SIX);

  // stage j: series value
  logic             vj;
  rbs_pkg::rbs_sqr_t ej;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
      vd <= 1'b0;
      ve <= 1'b0;
      vf <= 1'b0;
      vg <= 1'b0;
      vh <= 1'b0;
      vi <= 1'b0;
      vj <= 1'b0;
    end else if (en) begin
      vc <= dv_v[DIV_STEPS_L];
      vd <= vc;
      ve <= vd;
      vf <= ve;
      vg <= vf;
      vh <= vg;
      vi <= vh;
      vj <= vi;
    end
    if (en) begin
      a_c     <= eta_cos[32:8];
      k_c     <= kv;
      pl_d    <= 42'(a_c) * 42'(k_c[16:0]);
      ph_d    <= 42'(a_c) * 42'(k_c[33:17]);
      x_e     <= prod_ak[32:15];
      zero_e  <= prod_ak[58:33] != 26'd0;
      y_f     <= xx[35:16];
      zero_f  <= zero_e;
      t_g     <= {y_f, 3'b000};
      t2_g    <= tt[45:31];
      zero_g  <= zero_f;
      t_h     <= t_g;
      t2_h    <= t2_g;
      t3_h    <= t2t[37:31];
      zero_h  <= zero_g;
      t_i     <= t_h;
      t2_i    <= t2_h;
      d6_i    <= t3r[22:18];
      zero_i  <= zero_h;
      ej.e    <= rbs_pkg::E_ONE - 32'(t_i) + 32'(t2_i >> 1) - 32'(d6_i);
      ej.zero <= zero_i;
    end
  end

  // squaring row
  localparam int SQ_L = rbs_pkg::SQUARINGS;
  logic              sr_v [SQ_L+1];
  rbs_pkg::rbs_sqr_t sr_d [SQ_L+1];

  assign sr_v[0] = vj;
  assign sr_d[0] = ej;

  for (genvar i = 0; i < SQ_L; i++) begin : g_sqr
    rbs_sqr_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .vin  (sr_v[i]),
      .din  (sr_d[i]),
      .vout (sr_v[i+1]),
      .dout (sr_d[i+1])
    );
  end

  logic [32:0] pr;
  assign pr = (33'(sr_d[SQ_L].e) + 33'h4000) >> 15;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= sr_v[SQ_L];
    end
    if (en) begin
      if (sr_d[SQ_L].zero) begin
        specular_probability <= 16'd0;
      end else if (pr > 33'd65535) begin
        specular_probability <= 16'hFFFF;
      end else begin
        specular_probability <= pr[15:0];
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_root_narrow: assert property (@(posedge clk) disable iff (rst)
    sq_v[SQRT_STEPS_L] |-> sq_d[SQRT_STEPS_L].root[31:16] == 16'd0)
    else $error("square root wider than 16 bits");
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !vj && !vc)
    else $error("pipeline valid after reset");
`endif

endmodule

@@ tb/sv/rbs_checker.sv @@
module rbs_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] velocity_x,
  input  logic signed [15:0] velocity_y,
  input  logic signed [15:0] velocity_z,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic signed [15:0] normal_z,
  input  logic        [15:0] roughness_nm,
  input  logic        [15:0] angular_frequency,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic        [15:0] specular_probability,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [15:0] prob_queue[$];

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic [15:0] specularity(
    input logic signed [15:0] vx, vy, vz, nx, ny, nz,
    input logic [15:0] eta, omega);
    longint sx, sy, sz, dot;
    logic [63:0] s2, speed, adot, cosv, k, a, x, y, t, t2, t3, e, p;
    sx = vx; sy = vy; sz = vz;
    s2 = sx * sx + sy * sy + sz * sz;
    speed = int_sqrt(s2);
    if (speed < 1) speed = 1;
    dot = sx * longint'(nx) + sy * longint'(ny) + sz * longint'(nz);
    adot = (dot < 0) ? -dot : dot;
    cosv = (adot * 4) / speed;
    if (cosv > 65536) cosv = 65536;
    k = (64'(omega) << 18) / speed;
    if (k < 1) k = 1;
    a = (64'(eta) * cosv) >> 8;
    x = (a * k) >> 15;
    if (x >= (64'd4 << 16)) return 16'd0;
    y = (x * x) >> 16;
    t = y << 3;
    t2 = (t * t) >> 31;
    t3 = (t2 * t) >> 31;
    e = (64'd1 << 31) - t + (t2 >> 1) - (t3 / 6);
    for (int i = 0; i < 12; i++) e = (e * e + (64'd1 << 30)) >> 31;
    p = (e + (64'd1 << 14)) >> 15;
    if (p > 65535) p = 65535;
    return p[15:0];
  endfunction

  assign pending = prob_queue.size();

  always @(posedge clk) begin
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall)
        prob_queue = {prob_queue, specularity(velocity_x, velocity_y, velocity_z,
                                              normal_x, normal_y, normal_z,
                                              roughness_nm, angular_frequency)};
      if (out_valid && !out_stall) begin
        if (prob_queue.size() == 0) begin
          if (fail_count < 10) $display("unexpected beat: p=%0d", specular_probability);
          fail_count <= fail_count + 1;
        end else begin
          logic [15:0] want;
          want = prob_queue.pop_front();
          if (want !== specular_probability) begin
            if (fail_count < 10)
              $display("specular_probability: expected %0d, got %0d", want,
                       specular_probability);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

@@ tb/sv/tb_rough_boundary_specularity_core.sv @@
module tb_rough_boundary_specularity_core;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0, out_stall = 0;
  logic in_stall, out_valid;
  logic signed [15:0] velocity_x = 0, velocity_y = 0, velocity_z = 0;
  logic signed [15:0] normal_x = 0, normal_y = 0, normal_z = 0;
  logic [15:0] roughness_nm = 0, angular_frequency = 0, specular_probability;
  int fail_count, pending;
  bit busy_stretch = 0;

  always #4 clk = ~clk;

  rough_boundary_specularity_core i_dut (.*);
  rbs_checker i_checker (.*);

  // receiver stalls at random, except during the steady stretch
  always @(posedge clk)
    out_stall <= !busy_stretch && ($urandom_range(99) < 32);

  function automatic logic signed [15:0] rand_normal();
    return $signed(16'($urandom_range(32768))) - 16'sd16384;
  endfunction

  task automatic send_hit(input logic [15:0] vx, vy, vz, nx, ny, nz, eta, omega);
    while (!busy_stretch && $urandom_range(99) < 32) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    velocity_x <= vx; velocity_y <= vy; velocity_z <= vz;
    normal_x <= nx; normal_y <= ny; normal_z <= nz;
    roughness_nm <= eta; angular_frequency <= omega;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_random_hit();
    logic [15:0] vx, vy, vz, eta, omega;
    vx = $urandom; vy = $urandom; vz = $urandom;
    eta = $urandom; omega = $urandom;
    // mostly small roughness/frequency so p spans the whole range
    if ($urandom_range(3) != 0) begin
      eta = $urandom_range(0, 1023);
      omega = $urandom_range(0, 1023);
      if ($urandom_range(1)) begin
        vx = $signed(vx) >>> 4; vy = $signed(vy) >>> 4; vz = $signed(vz) >>> 4;
      end
    end
    send_hit(vx, vy, vz, rand_normal(), rand_normal(), rand_normal(), eta, omega);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_hit(0, 0, 0, 16384, 0, 0, 256, 256);          // zero velocity
    send_hit(1024, 0, 0, 16384, 0, 0, 256, 0);         // zero frequency
    send_hit(1024, 0, 0, 16384, 0, 0, 0, 256);         // zero roughness
    send_hit(1024, 0, 0, -16384, 0, 0, 65535, 65535);  // large exponent
    send_hit(1024, 0, 0, 0, 16384, 0, 65535, 65535);   // grazing
    send_hit(16'h8000, 16'h8000, 16'h8000, 16'hc000, 16'hc000, 16'hc000, 65535, 65535);
    send_hit(16'h7fff, 16'h7fff, 16'h7fff, 16384, 16384, 16384, 1, 1); // non-unit normal
    send_hit(16'h7fff, 16'h8000, 16'h0001, 16'hc000, 16384, 0, 16, 16);
    send_hit(1, 0, 0, 16384, 0, 0, 65535, 1);
    send_hit(1024, 0, 0, 16384, 0, 0, 64, 300);
    send_hit(1024, 0, 0, 16384, 0, 0, 128, 300);
    send_hit(-1024, 512, 0, 12000, 8000, 0, 200, 200);
    for (int i = 0; i < 640; i++) begin
      busy_stretch = (i >= 200 && i < 320);
      send_random_hit();
    end
    busy_stretch = 0;
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #2ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
